/* rtl/core/tadc_pkg.sv */
// tadc_pkg: payload types, register map, status/event codes and duty scaling
// for the timed actuator door controller. No dependencies.

package tadc_pkg;

  localparam int unsigned PWM_TOP = 999;

  localparam int unsigned DUTY_W  = 10;
  localparam int unsigned TRAVEL_W = 16;
  localparam int unsigned SPEED_W = 7;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [TRAVEL_W-1:0] OPEN_TRAVEL_RST  = 16'd8000;
  localparam logic [TRAVEL_W-1:0] CLOSE_TRAVEL_RST = 16'd8000;
  localparam logic [SPEED_W-1:0]  SPEED_RST        = 7'd50;
  localparam logic [SPEED_W-1:0]  SPEED_MAX        = 7'd100;
  localparam logic [TRAVEL_W-1:0] ELAPSED_MAX      = '1;
  localparam logic [DUTY_W-1:0]   DUTY_MAX         = '1;

  // Divide by 100 as multiply by ceil(2^32/100) and shift.
  localparam int unsigned  RECIP_SHIFT = 32;
  localparam logic [63:0]  RECIP_100   = ((64'd1 << RECIP_SHIFT) / 64'd100) + 64'd1;
  localparam logic [63:0]  DUTY_MUL    = 64'(PWM_TOP) * RECIP_100;

  localparam logic [1:0] REG_OPEN_TRAVEL  = 2'd0;
  localparam logic [1:0] REG_CLOSE_TRAVEL = 2'd1;
  localparam logic [1:0] REG_SPEED        = 2'd2;

  localparam logic [2:0] ST_STOPPED = 3'd0;
  localparam logic [2:0] ST_OPENING = 3'd1;
  localparam logic [2:0] ST_CLOSING = 3'd2;
  localparam logic [2:0] ST_OPEN    = 3'd3;
  localparam logic [2:0] ST_CLOSED  = 3'd4;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_OPENING = 3'd1;
  localparam logic [2:0] EV_CLOSING = 3'd2;
  localparam logic [2:0] EV_STOPPED = 3'd3;
  localparam logic [2:0] EV_OPENED  = 3'd4;
  localparam logic [2:0] EV_CLOSED  = 3'd5;
  localparam logic [2:0] EV_UNKNOWN = 3'd6;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CMD  = 1'b1;

  localparam logic DIR_CLOSE = 1'b0;
  localparam logic DIR_OPEN  = 1'b1;

  localparam logic [7:0] CH_LOWER = 8'h20;
  localparam logic [7:0] CH_O  = 8'h6f;
  localparam logic [7:0] CH_C  = 8'h63;
  localparam logic [7:0] CH_S  = 8'h73;
  localparam logic [7:0] CH_T  = 8'h74;
  localparam logic [7:0] CH_B  = 8'h62;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef struct packed {
    logic       req_type;
    logic [7:0] cmd_byte;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic              drive_dir;
    logic [2:0]        door_status;
    logic [2:0]        event_code;
  } out_t;

  // speed_percent*PWM_TOP/100, speed clamped to 100, result saturated.
  function automatic logic [DUTY_W-1:0] drive_duty(input logic [SPEED_W-1:0] pct);
    logic [SPEED_W-1:0] p;
    logic [71:0]        prod;
    logic [39:0]        q;
    p    = (pct > SPEED_MAX) ? SPEED_MAX : pct;
    prod = 72'(p) * 72'(DUTY_MUL);
    q    = prod[RECIP_SHIFT +: 40];
    return (q > 40'(DUTY_MAX)) ? DUTY_MAX : q[DUTY_W-1:0];
  endfunction

  localparam logic [DUTY_W-1:0] DUTY_RST = drive_duty(SPEED_RST);

endpackage

/* rtl/core/timed_actuator_door_controller.sv */
// Timed actuator door controller top level: APB register file, door state
// and registered result stage. Depends on tadc_pkg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------
//   in       | in_valid / in_ready   | tadc_pkg::in_t  (tick or byte)
//   out      | out_valid / out_ready | tadc_pkg::out_t (one per item)
//   cfg      | APB psel/penable      | 32-bit registers at 4*i
//
// One item per cycle: the state update and result are computed in the
// accept cycle and land in the state and output registers at that edge.
// in_ready is high whenever the output register is empty or being taken.
// Synchronous active-low reset; stalls on out_ready hold the result and
// block further input until it is taken. No clearing pass after reset.

module timed_actuator_door_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tadc_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tadc_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tadc_pkg::ADDR_W-1:0]   paddr,
  input  logic [tadc_pkg::DATA_W-1:0]   pwdata,
  output logic [tadc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [tadc_pkg::TRAVEL_W-1:0] open_travel_r;
  logic [tadc_pkg::TRAVEL_W-1:0] close_travel_r;
  logic [tadc_pkg::SPEED_W-1:0]  speed_r;
  logic [tadc_pkg::DUTY_W-1:0]   duty_cfg_r;

  logic [2:0]                    mode_r, mode_nxt;
  logic [tadc_pkg::TRAVEL_W-1:0] elapsed_r, elapsed_nxt;
  logic                          dir_r, dir_nxt;
  logic [tadc_pkg::DUTY_W-1:0]   duty_r, duty_nxt;
  logic [2:0]                    ev;

  logic                          out_valid_r;
  tadc_pkg::out_t                out_r;

  logic                          cfg_wr;
  logic [1:0]                    reg_idx;
  logic                          accept;
  logic [7:0]                    lc;
  logic [tadc_pkg::TRAVEL_W-1:0] el_inc;
  logic                          do_open, do_close;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (reg_idx)
      tadc_pkg::REG_OPEN_TRAVEL:  prdata = 32'(open_travel_r);
      tadc_pkg::REG_CLOSE_TRAVEL: prdata = 32'(close_travel_r);
      tadc_pkg::REG_SPEED:        prdata = 32'(speed_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_travel_r  <= tadc_pkg::OPEN_TRAVEL_RST;
      close_travel_r <= tadc_pkg::CLOSE_TRAVEL_RST;
      speed_r        <= tadc_pkg::SPEED_RST;
      duty_cfg_r     <= tadc_pkg::DUTY_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        tadc_pkg::REG_OPEN_TRAVEL:  open_travel_r  <= pwdata[tadc_pkg::TRAVEL_W-1:0];
        tadc_pkg::REG_CLOSE_TRAVEL: close_travel_r <= pwdata[tadc_pkg::TRAVEL_W-1:0];
        tadc_pkg::REG_SPEED: begin
          speed_r    <= pwdata[tadc_pkg::SPEED_W-1:0];
          duty_cfg_r <= tadc_pkg::drive_duty(pwdata[tadc_pkg::SPEED_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  assign lc     = in_data.cmd_byte | tadc_pkg::CH_LOWER;
  assign el_inc = (elapsed_r == tadc_pkg::ELAPSED_MAX) ? elapsed_r
                                                       : elapsed_r + 1'b1;

  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    dir_nxt     = dir_r;
    duty_nxt    = duty_r;
    ev          = tadc_pkg::EV_NONE;
    do_open     = 1'b0;
    do_close    = 1'b0;
    if (in_data.req_type == tadc_pkg::REQ_TICK) begin
      elapsed_nxt = el_inc;
      if (mode_r == tadc_pkg::ST_OPENING && el_inc >= open_travel_r) begin
        duty_nxt = '0;
        mode_nxt = tadc_pkg::ST_OPEN;
        ev       = tadc_pkg::EV_OPENED;
      end else if (mode_r == tadc_pkg::ST_CLOSING && el_inc >= close_travel_r) begin
        duty_nxt = '0;
        mode_nxt = tadc_pkg::ST_CLOSED;
        ev       = tadc_pkg::EV_CLOSED;
      end
    end else begin
      if (lc == tadc_pkg::CH_O) begin
        do_open = 1'b1;
      end else if (lc == tadc_pkg::CH_C) begin
        do_close = 1'b1;
      end else if (lc == tadc_pkg::CH_S) begin
        duty_nxt = '0;
        mode_nxt = tadc_pkg::ST_STOPPED;
        ev       = tadc_pkg::EV_STOPPED;
      end else if (lc == tadc_pkg::CH_T || lc == tadc_pkg::CH_B) begin
        if (mode_r == tadc_pkg::ST_OPEN || mode_r == tadc_pkg::ST_OPENING) begin
          do_close = 1'b1;
        end else begin
          do_open = 1'b1;
        end
      end else if (in_data.cmd_byte == tadc_pkg::CH_CR ||
                   in_data.cmd_byte == tadc_pkg::CH_LF) begin
        ev = tadc_pkg::EV_NONE;
      end else begin
        ev = tadc_pkg::EV_UNKNOWN;
      end
      if (do_open) begin
        dir_nxt     = tadc_pkg::DIR_OPEN;
        duty_nxt    = duty_cfg_r;
        elapsed_nxt = '0;
        mode_nxt    = tadc_pkg::ST_OPENING;
        ev          = tadc_pkg::EV_OPENING;
      end else if (do_close) begin
        dir_nxt     = tadc_pkg::DIR_CLOSE;
        duty_nxt    = duty_cfg_r;
        elapsed_nxt = '0;
        mode_nxt    = tadc_pkg::ST_CLOSING;
        ev          = tadc_pkg::EV_CLOSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tadc_pkg::ST_STOPPED;
      elapsed_r   <= '0;
      dir_r       <= tadc_pkg::DIR_CLOSE;
      duty_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r    <= mode_nxt;
        elapsed_r <= elapsed_nxt;
        dir_r     <= dir_nxt;
        duty_r    <= duty_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.pwm_duty    <= duty_nxt;
      out_r.drive_dir   <= dir_nxt;
      out_r.door_status <= mode_nxt;
      out_r.event_code  <= ev;
    end
  end

endmodule

/* rtl/core/tadc_checker.sv */
// tadc_checker: port-level assertions for the door controller, bound to
// the top level below. Depends on tadc_pkg.

module tadc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input tadc_pkg::out_t out_data,
  input logic           pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.door_status <= tadc_pkg::ST_CLOSED)
    else $error("door_status out of range");

  a_idle_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.door_status != tadc_pkg::ST_OPENING &&
    out_data.door_status != tadc_pkg::ST_CLOSING |-> out_data.pwm_duty == '0)
    else $error("duty nonzero while not moving");

  a_open_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_code == tadc_pkg::EV_OPENING |->
    out_data.door_status == tadc_pkg::ST_OPENING &&
    out_data.drive_dir == tadc_pkg::DIR_OPEN)
    else $error("opening event without opening state");

  a_close_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_code == tadc_pkg::EV_CLOSING |->
    out_data.door_status == tadc_pkg::ST_CLOSING &&
    out_data.drive_dir == tadc_pkg::DIR_CLOSE && pready)
    else $error("closing event without closing state");

endmodule

bind timed_actuator_door_controller tadc_checker u_tadc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
